### design/dpb_pkg.sv
// Shared types, constants and the stride reciprocal table for the
// depth pixel back-projection block. No dependencies.
package dpb_pkg;

  localparam int unsigned MaxImageSide = 4096;
  localparam int unsigned RecipShift   = 17;
  localparam int unsigned CfgIdxWidth  = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegPixelStride,
    RegInvFocalX,
    RegInvFocalY,
    RegPrincipalPoint,
    RegPoseRowX,
    RegPoseRowY,
    RegPoseRowZ
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    rgb_t               rgb;
  } point_t;

  typedef struct packed {
    logic [4:0]        stride;
    logic [17:0]       stride_recip;
    logic [31:0]       inv_fx;
    logic [31:0]       inv_fy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [2:0][63:0]  pose;
  } cfg_t;

  // ceil(2^17 / s): floor(n * recip >> 17) == n / s for n < 4096, s < 32
  function automatic logic [17:0] stride_recip(input logic [4:0] s);
    logic [17:0] r;
    case (s)
      5'd2:    r = 18'd65536;
      5'd3:    r = 18'd43691;
      5'd4:    r = 18'd32768;
      5'd5:    r = 18'd26215;
      5'd6:    r = 18'd21846;
      5'd7:    r = 18'd18725;
      5'd8:    r = 18'd16384;
      5'd9:    r = 18'd14564;
      5'd10:   r = 18'd13108;
      5'd11:   r = 18'd11916;
      5'd12:   r = 18'd10923;
      5'd13:   r = 18'd10083;
      5'd14:   r = 18'd9363;
      5'd15:   r = 18'd8739;
      5'd16:   r = 18'd8192;
      5'd17:   r = 18'd7711;
      5'd18:   r = 18'd7282;
      5'd19:   r = 18'd6899;
      5'd20:   r = 18'd6554;
      5'd21:   r = 18'd6242;
      5'd22:   r = 18'd5958;
      5'd23:   r = 18'd5699;
      5'd24:   r = 18'd5462;
      5'd25:   r = 18'd5243;
      5'd26:   r = 18'd5042;
      5'd27:   r = 18'd4855;
      5'd28:   r = 18'd4682;
      5'd29:   r = 18'd4520;
      5'd30:   r = 18'd4370;
      5'd31:   r = 18'd4229;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

### design/depth_pixel_backprojection.sv
// Depth pixel back-projection: one depth pixel (Q16.16 depth, column, row,
// RGB) in per clock, one world point out per kept pixel. Throughput is one
// item per cycle; the six pipeline stages each carry a valid bit and an
// empty stage fills even while the output waits, so backpressure only stops
// input once every stage holds an item. Pixels with non-positive depth or
// column/row not a multiple of pixel_stride give no result. Config
// writes take effect on the next cycle and are meant for when the pipeline
// is empty.
// Depends on dpb_pkg, dpb_cfg, dpb_cam, dpb_pose.
module depth_pixel_backprojection (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dpb_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [63:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [31:0]             depth_value_i,
  input  logic [11:0]                    column_i,
  input  logic [11:0]                    row_i,
  input  logic [7:0]                     red_in_i,
  input  logic [7:0]                     green_in_i,
  input  logic [7:0]                     blue_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             point_x_o,
  output logic signed [31:0]             point_y_o,
  output logic signed [31:0]             point_z_o,
  output logic [7:0]                     red_out_o,
  output logic [7:0]                     green_out_o,
  output logic [7:0]                     blue_out_o
);
  import dpb_pkg::*;

  cfg_t   cfg;
  rgb_t   rgb_in;
  point_t cam_point, out_point;
  logic   cam_valid, pose_ready;

  assign cfg_ready_o  = 1'b1;
  assign rgb_in.red   = red_in_i;
  assign rgb_in.green = green_in_i;
  assign rgb_in.blue  = blue_in_i;

  dpb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dpb_cam u_cam (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .depth_value_i (depth_value_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .rgb_i         (rgb_in),
    .out_valid_o   (cam_valid),
    .out_ready_i   (pose_ready),
    .point_o       (cam_point)
  );

  dpb_pose u_pose (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (cam_valid),
    .in_ready_o  (pose_ready),
    .point_i     (cam_point),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .point_o     (out_point)
  );

  assign point_x_o   = out_point.x;
  assign point_y_o   = out_point.y;
  assign point_z_o   = out_point.z;
  assign red_out_o   = out_point.rgb.red;
  assign green_out_o = out_point.rgb.green;
  assign blue_out_o  = out_point.rgb.blue;

  // an empty output register means every stage can move
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // input backpressure only ever comes from a stalled output
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  // the pose stages refuse an item only when full and stalled
  a_pose_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cam_valid && !pose_ready) |-> (out_valid_o && !out_ready_i))
    else $error("pose stage stalled without output backpressure");

endmodule

### design/dpb_cfg.sv
// Configuration register file: stride (with its reciprocal), focal
// reciprocals, principal point and pose rows. Depends on dpb_pkg.
module dpb_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [dpb_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [63:0]                    cfg_data_i,
  output dpb_pkg::cfg_t                  cfg_o
);
  import dpb_pkg::*;

  localparam cfg_t CfgReset = '{
    stride:       5'd1,
    stride_recip: stride_recip(5'd1),
    inv_fx:       '0,
    inv_fy:       '0,
    cx:           '0,
    cy:           '0,
    pose:         '0
  };

  cfg_t       cfg_q, cfg_d;
  logic [4:0] stride_eff;

  always_comb begin
    stride_eff = (cfg_data_i[4:0] == 5'd0) ? 5'd1 : cfg_data_i[4:0];
    cfg_d      = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegPixelStride: begin
          cfg_d.stride       = stride_eff;
          cfg_d.stride_recip = stride_recip(stride_eff);
        end
        RegInvFocalX:      cfg_d.inv_fx  = cfg_data_i[31:0];
        RegInvFocalY:      cfg_d.inv_fy  = cfg_data_i[31:0];
        RegPrincipalPoint: begin
          cfg_d.cx = cfg_data_i[31:0];
          cfg_d.cy = cfg_data_i[63:32];
        end
        RegPoseRowX:       cfg_d.pose[0] = cfg_data_i;
        RegPoseRowY:       cfg_d.pose[1] = cfg_data_i;
        RegPoseRowZ:       cfg_d.pose[2] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/dpb_cam.sv
// Four-stage front end: pixel filter and camera-frame back-projection
// x = (col-cx)*z/fx, y = (row-cy)*z/fy. Depends on dpb_pkg.
module dpb_cam (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpb_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] depth_value_i,
  input  logic [11:0]        column_i,
  input  logic [11:0]        row_i,
  input  dpb_pkg::rgb_t      rgb_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dpb_pkg::point_t    point_o
);
  import dpb_pkg::*;

  localparam int Stages = 4;

  logic [Stages-1:0] v_q, en;

  // stage 1: offsets from the principal point, stride products
  logic signed [33:0] dx, dy;
  logic [33:0]        dx_mag, dy_mag;
  logic               keep1_d;
  logic [31:0]        mx_q, my_q;
  logic               negx1_q, negy1_q, keep1_q;
  logic [30:0]        z1_q;
  rgb_t               rgb1_q;
  logic [11:0]        col1_q, row1_q;
  logic [29:0]        cprod_q, rprod_q;

  // stage 2: |d| * z
  logic [62:0]        px_full, py_full;
  logic               stride_ok;
  logic [46:0]        px_q, py_q;
  logic               negx2_q, negy2_q;
  logic [30:0]        z2_q;
  rgb_t               rgb2_q;

  // stage 3: scale by focal reciprocals
  logic [46:0]        hx_q, hy_q;
  logic [63:0]        lx_q, ly_q;
  logic               negx3_q, negy3_q;
  logic [30:0]        z3_q;
  rgb_t               rgb3_q;

  // stage 4: sign and saturate
  point_t             point_q;

  function automatic logic signed [31:0] sat_coord(input logic [46:0] h,
                                                    input logic [63:0] l,
                                                    input logic        neg);
    logic [48:0] r;
    logic [31:0] res;
    r = {1'b0, h, 1'b0} + 49'(l[63:31]);
    if (!neg) begin
      res = (r > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    end else begin
      res = (r > 49'h0_8000_0000) ? 32'h8000_0000 : 32'(-r[31:0]);
    end
    return $signed(res);
  endfunction

  // a stage moves when empty or when the one after it moves
  always_comb begin
    en[Stages-1] = !v_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    dx      = $signed({6'd0, column_i, 16'd0}) - 34'(cfg_i.cx);
    dy      = $signed({6'd0, row_i, 16'd0}) - 34'(cfg_i.cy);
    dx_mag  = dx[33] ? 34'(-dx) : dx;
    dy_mag  = dy[33] ? 34'(-dy) : dy;
    keep1_d = !depth_value_i[31] && (depth_value_i != 32'sd0) &&
              (32'(column_i) < MaxImageSide) && (32'(row_i) < MaxImageSide);
  end

  always_comb begin
    px_full   = 63'(mx_q) * 63'(z1_q);
    py_full   = 63'(my_q) * 63'(z1_q);
    stride_ok = (18'(cprod_q[29:RecipShift]) * 18'(cfg_i.stride) == 18'(col1_q)) &&
                (18'(rprod_q[29:RecipShift]) * 18'(cfg_i.stride) == 18'(row1_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0] && keep1_q && stride_ok;
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mx_q    <= dx_mag[31:0];
      my_q    <= dy_mag[31:0];
      negx1_q <= dx[33];
      negy1_q <= dy[33];
      keep1_q <= keep1_d;
      z1_q    <= depth_value_i[30:0];
      rgb1_q  <= rgb_i;
      col1_q  <= column_i;
      row1_q  <= row_i;
      cprod_q <= 30'(column_i) * 30'(cfg_i.stride_recip);
      rprod_q <= 30'(row_i) * 30'(cfg_i.stride_recip);
    end
    if (en[1]) begin
      px_q    <= px_full[62:16];
      py_q    <= py_full[62:16];
      negx2_q <= negx1_q;
      negy2_q <= negy1_q;
      z2_q    <= z1_q;
      rgb2_q  <= rgb1_q;
    end
    if (en[2]) begin
      hx_q    <= 47'(px_q[46:32]) * 47'(cfg_i.inv_fx);
      lx_q    <= 64'(px_q[31:0]) * 64'(cfg_i.inv_fx);
      hy_q    <= 47'(py_q[46:32]) * 47'(cfg_i.inv_fy);
      ly_q    <= 64'(py_q[31:0]) * 64'(cfg_i.inv_fy);
      negx3_q <= negx2_q;
      negy3_q <= negy2_q;
      z3_q    <= z2_q;
      rgb3_q  <= rgb2_q;
    end
    if (en[3]) begin
      point_q.x   <= sat_coord(hx_q, lx_q, negx3_q);
      point_q.y   <= sat_coord(hy_q, ly_q, negy3_q);
      point_q.z   <= $signed({1'b0, z3_q});
      point_q.rgb <= rgb3_q;
    end
  end

  assign out_valid_o = v_q[Stages-1];
  assign point_o     = point_q;

endmodule

### design/dpb_pose.sv
// Two-stage pose transform: three 16x32 products per row, then the sum with
// translation, round to Q16.16 and saturate. Last stage is the output register.
// Depends on dpb_pkg.
module dpb_pose (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dpb_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dpb_pkg::point_t point_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dpb_pkg::point_t point_o
);
  import dpb_pkg::*;

  logic [1:0] v_q, en;

  logic signed [47:0] p0_q [3];
  logic signed [47:0] p1_q [3];
  logic signed [47:0] p2_q [3];
  logic signed [15:0] t_q  [3];
  rgb_t               rgb1_q;

  logic signed [50:0] acc   [3];
  logic signed [38:0] shr   [3];
  logic signed [31:0] res_d [3];
  point_t             point_q;

  assign en[1]      = !v_q[1] || out_ready_i;
  assign en[0]      = !v_q[0] || en[1];
  assign in_ready_o = en[0];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = 51'(p0_q[j]) + 51'(p1_q[j]) + 51'(p2_q[j]) +
               $signed({{19{t_q[j][15]}}, t_q[j], 16'd0}) + 51'sd2048;
      shr[j] = acc[j][50:12];
      if (shr[j] > 39'sd2147483647) begin
        res_d[j] = 32'sh7FFF_FFFF;
      end else if (shr[j] < -39'sd2147483648) begin
        res_d[j] = 32'sh8000_0000;
      end else begin
        res_d[j] = shr[j][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int j = 0; j < 3; j++) begin
        p0_q[j] <= $signed(cfg_i.pose[j][15:0]) * point_i.x;
        p1_q[j] <= $signed(cfg_i.pose[j][31:16]) * point_i.y;
        p2_q[j] <= $signed(cfg_i.pose[j][47:32]) * point_i.z;
        t_q[j]  <= cfg_i.pose[j][63:48];
      end
      rgb1_q <= point_i.rgb;
    end
    if (en[1]) begin
      point_q.x   <= res_d[0];
      point_q.y   <= res_d[1];
      point_q.z   <= res_d[2];
      point_q.rgb <= rgb1_q;
    end
  end

  assign out_valid_o = v_q[1];
  assign point_o     = point_q;

endmodule

### test/depth_pixel_backprojection_tb.sv
// Self-checking bench for depth_pixel_backprojection: directed corner pixels, then
// randomly configured phases of mostly kept pixels, checked against a built-in projector.
// Depends on dpb_pkg and the block's RTL only.
module depth_pixel_backprojection_tb;
  import dpb_pkg::*;

  localparam int unsigned PipeDepth = 6;
  localparam logic [CfgIdxWidth-1:0] RegNone = 3'd7;  // no register behind this index
  localparam longint Q16Max = 64'sd2147483647;
  localparam longint Q16Min = -64'sd2147483648;

  class world_point_tracker;
    logic [4:0]  stride;
    logic [31:0] inv_fx;
    logic [31:0] inv_fy;
    logic [63:0] center;
    logic [63:0] pose [3];
    point_t      pending_points [$];
    int unsigned mismatches;

    function new();
      stride = 5'd1;
      inv_fx = '0;
      inv_fy = '0;
      center = '0;
      foreach (pose[i]) pose[i] = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [63:0] data);
      case (idx)
        RegPixelStride:    stride = data[4:0];
        RegInvFocalX:      inv_fx = data[31:0];
        RegInvFocalY:      inv_fy = data[31:0];
        RegPrincipalPoint: center = data;
        RegPoseRowX:       pose[0] = data;
        RegPoseRowY:       pose[1] = data;
        RegPoseRowZ:       pose[2] = data;
        default: ;
      endcase
    endfunction

    function longint clamp_q16(longint v);
      if (v > Q16Max) return Q16Max;
      if (v < Q16Min) return Q16Min;
      return v;
    endfunction

    // magnitude path: (|d|*z >> 16) * inv >> 31, sign restored afterwards
    function longint cam_axis(longint d, longint z, logic [31:0] inv);
      logic        neg;
      logic [63:0] m, p, lo, hi, r;
      longint      s;
      neg = d < 0;
      m = neg ? -d : d;
      p = (m * z) >> 16;
      lo = {32'd0, p[31:0]};
      hi = p >> 32;
      r = hi * inv * 2 + ((lo * inv) >> 31);
      s = $signed(r);
      return clamp_q16(neg ? -s : s);
    endfunction

    function longint world_axis(logic [63:0] rowv, longint x, longint y, longint z);
      longint r0, r1, r2, t, acc;
      r0 = $signed(rowv[15:0]);
      r1 = $signed(rowv[31:16]);
      r2 = $signed(rowv[47:32]);
      t  = $signed(rowv[63:48]);
      acc = r0 * x + r1 * y + r2 * z + t * 65536;
      return clamp_q16((acc + 2048) >>> 12);
    endfunction

    function void note_pixel(logic signed [31:0] depth, logic [11:0] col, logic [11:0] row,
                             rgb_t rgb);
      logic [4:0] s;
      longint     z, cx, cy, xc, yc;
      point_t     pt;
      s = (stride == 5'd0) ? 5'd1 : stride;
      z = depth;
      if (z <= 0) return;
      if ((col % s) != 0 || (row % s) != 0) return;
      cx = $signed(center[31:0]);
      cy = $signed(center[63:32]);
      xc = cam_axis(longint'(col) * 65536 - cx, z, inv_fx);
      yc = cam_axis(longint'(row) * 65536 - cy, z, inv_fy);
      pt.x = int'(world_axis(pose[0], xc, yc, z));
      pt.y = int'(world_axis(pose[1], xc, yc, z));
      pt.z = int'(world_axis(pose[2], xc, yc, z));
      pt.rgb = rgb;
      pending_points.push_back(pt);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (pending_points.size() == 0) begin
        mismatches++;
        $error("point out with no kept pixel waiting");
        return;
      end
      want = pending_points.pop_front();
      compare_field("point_x", want.x, got.x);
      compare_field("point_y", want.y, got.y);
      compare_field("point_z", want.z, got.z);
      compare_field("red_out", want.rgb.red, got.rgb.red);
      compare_field("green_out", want.rgb.green, got.rgb.green);
      compare_field("blue_out", want.rgb.blue, got.rgb.blue);
    endfunction

    function int pending();
      return pending_points.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [63:0]            cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic signed [31:0]     depth_value_i;
  logic [11:0]            column_i;
  logic [11:0]            row_i;
  logic [7:0]             red_in_i;
  logic [7:0]             green_in_i;
  logic [7:0]             blue_in_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic signed [31:0]     point_x_o;
  logic signed [31:0]     point_y_o;
  logic signed [31:0]     point_z_o;
  logic [7:0]             red_out_o;
  logic [7:0]             green_out_o;
  logic [7:0]             blue_out_o;

  world_point_tracker board = new();
  logic [4:0]  cur_stride = 5'd1;
  int unsigned pixels_sent = 0;
  bit          sender_steady = 1'b0;

  depth_pixel_backprojection dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .depth_value_i (depth_value_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_z_o     (point_z_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [63:0] data);
    int unsigned gap;
    gap = $urandom_range(0, 2);
    if (gap > 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  // stray write goes last so a decode that aliases it would corrupt a live register
  task automatic load_config(logic [4:0] stride, logic [31:0] ifx, logic [31:0] ify,
                             logic [63:0] center, logic [63:0] px, logic [63:0] py,
                             logic [63:0] pz, bit stray);
    write_reg(RegPixelStride, {59'd0, stride});
    write_reg(RegInvFocalX, {32'd0, ifx});
    write_reg(RegInvFocalY, {32'd0, ify});
    write_reg(RegPrincipalPoint, center);
    write_reg(RegPoseRowX, px);
    write_reg(RegPoseRowY, py);
    write_reg(RegPoseRowZ, pz);
    if (stray) write_reg(RegNone, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    cur_stride = stride;
  endtask

  task automatic send_pixel(logic signed [31:0] depth, logic [11:0] col, logic [11:0] row,
                            rgb_t rgb);
    int unsigned gap;
    if (pixels_sent % 50 == 0) sender_steady = ($urandom_range(0, 2) == 0);
    gap = sender_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    depth_value_i <= depth;
    column_i      <= col;
    row_i         <= row;
    red_in_i      <= rgb.red;
    green_in_i    <= rgb.green;
    blue_in_i     <= rgb.blue;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_pixel(depth, col, row, rgb);
    pixels_sent++;
  endtask

  // dropped pixels leave no trace in the queue, so give the pipe time to empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  function automatic logic [4:0] draw_stride();
    case ($urandom_range(0, 5))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(2, 15));
    endcase
  endfunction

  function automatic logic [31:0] draw_inv();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(32'h0010_0000, 32'h0200_0000);
    endcase
  endfunction

  function automatic logic [63:0] draw_center();
    logic [31:0] cx, cy;
    if ($urandom_range(0, 2) == 0) return {$urandom, $urandom};
    cx = {4'd0, 12'($urandom_range(0, 4095)), 16'($urandom)};
    cy = {4'd0, 12'($urandom_range(0, 4095)), 16'($urandom)};
    return {cy, cx};
  endfunction

  // mostly rotation-sized terms; now and then any 64 bits
  function automatic logic [63:0] draw_pose_row();
    logic [15:0] r0, r1, r2;
    if ($urandom_range(0, 2) == 0) return {$urandom, $urandom};
    r0 = 16'($urandom_range(0, 32'h2000)) - 16'h1000;
    r1 = 16'($urandom_range(0, 32'h2000)) - 16'h1000;
    r2 = 16'($urandom_range(0, 32'h2000)) - 16'h1000;
    return {16'($urandom), r2, r1, r0};
  endfunction

  task automatic run_random_phase(int unsigned items);
    logic [4:0]         s;
    logic [31:0]        draw;
    logic signed [31:0] depth;
    logic [11:0]        col, row;
    load_config(draw_stride(), draw_inv(), draw_inv(), draw_center(), draw_pose_row(),
                draw_pose_row(), draw_pose_row(), $urandom_range(0, 3) == 0);
    s = (cur_stride == 5'd0) ? 5'd1 : cur_stride;
    repeat (items) begin
      if ($urandom_range(0, 4) != 0) begin
        col = 12'($urandom_range(0, 4095 / s) * s);
        row = 12'($urandom_range(0, 4095 / s) * s);
        depth = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 32'h000A_0000)
                                            : $urandom_range(1, 32'h7FFF_FFFF);
      end else begin
        draw = $urandom;
        depth = draw;
        draw = $urandom;
        col = draw[11:0];
        row = draw[23:12];
      end
      send_pixel(depth, col, row, 24'($urandom));
    end
    settle();
  endtask

  initial begin : stimulus
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    depth_value_i <= '0;
    column_i      <= '0;
    row_i         <= '0;
    red_in_i      <= '0;
    green_in_i    <= '0;
    blue_in_i     <= '0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // reset values: zero pose, stride 1
    send_pixel(32'sh0001_0000, 12'd4095, 12'd4095, 24'h123456);
    send_pixel(32'sh0000_0000, 12'd0, 12'd0, 24'hFFFFFF);
    settle();

    // identity rotation with a z translation, 640x480-style intrinsics
    load_config(5'd1, 32'h0041_8937, 32'h0044_4444, {32'h00F0_0000, 32'h0140_0000},
                64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                64'h0800_1000_0000_0000, 1'b0);
    send_pixel(32'sh7FFF_FFFF, 12'd0, 12'd0, 24'hFF00FF);
    send_pixel(32'sh0000_0001, 12'd4095, 12'd4095, 24'h00FF00);
    send_pixel(32'sh0001_0000, 12'd320, 12'd240, 24'h808080);
    send_pixel(32'sh0000_0000, 12'd320, 12'd240, 24'h010203);
    send_pixel(-32'sd1, 12'd10, 12'd10, 24'h040506);
    send_pixel(32'sh8000_0000, 12'd4095, 12'd0, 24'h070809);
    send_pixel(32'sh0002_8000, 12'd4095, 12'd0, 24'h00FF00);
    send_pixel(32'sh0000_8000, 12'd0, 12'd4095, 24'hFFFFFF);
    send_pixel(32'sh7FFF_FFFF, 12'd4095, 12'd4095, 24'h000000);
    settle();

    // stride 0 acts as 1, zero and full-scale reciprocals, extreme pose and center
    load_config(5'd0, 32'h0000_0000, 32'hFFFF_FFFF, {32'h7FFF_FFFF, 32'h8000_0000},
                64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                64'h7FFF_8000_0001_FFFF, 1'b1);
    send_pixel(32'sh0001_0000, 12'd1, 12'd3, 24'hA5A5A5);
    send_pixel(32'sh7FFF_FFFF, 12'd4095, 12'd0, 24'h5A5A5A);
    send_pixel(32'sh0000_0001, 12'd0, 12'd4095, 24'hC3C3C3);
    settle();

    // stride above 16 keeps multiples of itself
    load_config(5'd17, 32'h0041_8937, 32'h0041_8937, {32'h00F0_0000, 32'h0140_0000},
                64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                64'h0000_1000_0000_0000, 1'b0);
    send_pixel(32'sh0001_0000, 12'd17, 12'd34, 24'h112233);
    send_pixel(32'sh0001_0000, 12'd16, 12'd17, 24'h445566);
    send_pixel(32'sh0003_0000, 12'd4080, 12'd0, 24'h778899);
    settle();

    load_config(5'd16, 32'h0041_8937, 32'h0041_8937, {32'h00F0_0000, 32'h0140_0000},
                64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                64'h0000_1000_0000_0000, 1'b0);
    send_pixel(32'sh0001_0000, 12'd4080, 12'd4080, 24'hAABBCC);
    send_pixel(32'sh0001_0000, 12'd4095, 12'd4080, 24'hDDEEFF);
    send_pixel(32'sh0001_0000, 12'd0, 12'd8, 24'h010101);
    settle();

    repeat (12) run_random_phase(142);

    if (board.mismatches == 0 && board.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : receiver
    int unsigned stall;
    int unsigned served;
    bit          steady;
    point_t      got;
    out_ready_i <= 1'b0;
    served = 0;
    steady = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (served % 40 == 0) steady = ($urandom_range(0, 2) == 0);
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.x         = point_x_o;
      got.y         = point_y_o;
      got.z         = point_z_o;
      got.rgb.red   = red_out_o;
      got.rgb.green = green_out_o;
      got.rgb.blue  = blue_out_o;
      board.check_point(got);
      served++;
    end
  end

endmodule

### filelist.f
design/dpb_pkg.sv
design/dpb_cfg.sv
design/dpb_cam.sv
design/dpb_pose.sv
design/depth_pixel_backprojection.sv
test/depth_pixel_backprojection_tb.sv
